FILE: rtl/core/rfpb_pkg.sv
// Shared types, constants and helpers of the ridge frequency pair builder.
// Used by the channel interfaces, the arithmetic unit and the core.
package rfpb_pkg;

    // Default sizing
    localparam int LIST_DEPTH_DEF = 16;
    localparam int PAIR_LIMIT_DEF = 64;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int FREQ_W     = 24;
    localparam int FLOPS_W    = 48;
    localparam int Q_W        = 32;
    localparam int STATUS_W   = 3;
    localparam int LAT_W      = 48;
    localparam int AXIS_W     = 2;
    localparam int MAXP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Arithmetic unit: widest operand is the latency numerator
    localparam int ARITH_W   = 112;
    localparam int DIV_STEPS = ARITH_W;
    localparam int MsPerUs   = 1000;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_CPU = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_MEM = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BUILD   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PAIR         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_FRAME    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_K        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BASE_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_PAIRS     = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K_RATIO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_AXIS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAIRS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_FLOPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_CPU   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MEM   = 3'd6;

    // Sweep axis code for cpu sweep; all others sweep memory
    localparam logic [AXIS_W-1:0] AXIS_CPU = 2'd1;

    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic               start;
        arith_op_t          op;
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic               done;
        logic [ARITH_W-1:0] result;
    } arith_rsp_t;

    localparam arith_req_t ARITH_IDLE = '{start: 1'b0, op: ARITH_MUL, a: '0, b: '0};

    // Build a request; a is the multiplicand or dividend
    function automatic arith_req_t arith_issue(input arith_op_t op,
                                               input logic [ARITH_W-1:0] a,
                                               input logic [ARITH_W-1:0] b);
        arith_req_t r;
        r.start = 1'b1;
        r.op    = op;
        r.a     = a;
        r.b     = b;
        return r;
    endfunction

endpackage

FILE: rtl/core/rfpb_item_if.sv
// Input channel of the pair builder: valid/ready plus one command item.
// Depends on rfpb_pkg for field widths.
interface rfpb_item_if;
    logic                            valid;
    logic                            ready;
    logic [rfpb_pkg::CMD_W-1:0]      cmd;
    logic [rfpb_pkg::FREQ_W-1:0]     freq;
    logic [rfpb_pkg::FLOPS_W-1:0]    work_flops;
    logic [rfpb_pkg::Q_W-1:0]        intensity;

    modport source (output valid, cmd, freq, work_flops, intensity, input ready);
    modport sink   (input valid, cmd, freq, work_flops, intensity, output ready);
endinterface

FILE: rtl/core/rfpb_result_if.sv
// Output channel of the pair builder: valid/ready plus one result item.
// Depends on rfpb_pkg for field widths.
interface rfpb_result_if;
    logic                            valid;
    logic                            ready;
    logic [rfpb_pkg::STATUS_W-1:0]   status;
    logic [rfpb_pkg::FREQ_W-1:0]     cpu_freq;
    logic [rfpb_pkg::FREQ_W-1:0]     mem_freq;
    logic [rfpb_pkg::LAT_W-1:0]      latency_ms;
    logic                            last;

    modport source (output valid, status, cpu_freq, mem_freq, latency_ms, last, input ready);
    modport sink   (input valid, status, cpu_freq, mem_freq, latency_ms, last, output ready);
endinterface

FILE: rtl/core/ridge_frequency_pair_builder_core.sv
// Ridge frequency pair builder: sorted frequency lists, nearest-ridge matching,
// deduplicated pair list and latency prediction. Depends on rfpb_pkg,
// rfpb_item_if, rfpb_result_if and rfpb_arith.
//
// Usage: items carry a command. Clear and add commands change the CPU or memory
// list and give no result; an add is an insertion sort, and an add to a full
// list is dropped. A build gives either one status result or one result per
// kept pair with both frequencies nonzero, ascending by (cpu, mem), with last
// set on the final one. In cpu sweep each inner entry takes one shift-add
// multiply; each new pair key is checked for duplicates and insertion sorted.
// Multiplies are shift-add and the division is a 112-step restoring division,
// all on the single shared arithmetic unit. Items are taken only while the
// sequencer is idle, one at a time. Results sit in an output register; the
// sequencer stalls on it only when it has a new result and the old one has
// not been taken. The next item may be accepted while the final result still
// waits. Reset empties both lists and loads register defaults; no clearing
// pass is needed.
module ridge_frequency_pair_builder_core #(
    parameter int LIST_DEPTH = rfpb_pkg::LIST_DEPTH_DEF,
    parameter int PAIR_LIMIT = rfpb_pkg::PAIR_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rfpb_item_if.sink                         items,
    rfpb_result_if.source                     results,
    input  logic                              cfg_we,
    input  logic [rfpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfpb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rfpb_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int PROD_W = 2 * Q_W;
    localparam int TGT_W = FREQ_W + PROD_W;
    localparam int KEY_W = 2 * FREQ_W;
    localparam int BLF_W = Q_W + FLOPS_W;
    localparam int LIM_W = MAXP_W + 1;

    typedef enum logic [5:0] {
        S_IDLE, S_ADD_RD, S_ADD_CMP, S_CHECK, S_STATUS,
        S_PROD_WT, S_BLF_WT,
        S_OUT_RD, S_OUT_LD, S_TGT_WT,
        S_IN_RD, S_IN_LD, S_A_WT, S_DIFF, S_CMP, S_FIN,
        S_DUP_RD, S_DUP_CMP, S_INS_RD, S_INS_CMP,
        S_LIMIT, S_SCAN_RD, S_SCAN_CMP,
        S_EMIT_RD, S_EMIT_LD, S_R1_WT, S_R2_WT, S_N_WT, S_D1_WT, S_D2_WT,
        S_DIV_WT, S_PUT
    } state_t;

    // Configuration registers
    logic [Q_W-1:0]        k_ratio_reg;
    logic [AXIS_W-1:0]     sweep_axis_reg;
    logic [MAXP_W-1:0]     max_pairs_reg;
    logic [Q_W-1:0]        base_latency_reg;
    logic [FLOPS_W-1:0]    base_flops_reg;
    logic [FREQ_W-1:0]     base_cpu_reg;
    logic [FREQ_W-1:0]     base_mem_reg;

    // Sequencer state
    state_t                state_reg;
    logic [CNT_W-1:0]      cpu_cnt_reg;
    logic [CNT_W-1:0]      mem_cnt_reg;
    logic                  add_cpu_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [FLOPS_W-1:0]    flops_reg;
    logic [Q_W-1:0]        ai_reg;
    logic                  cpu_sweep_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      jdx_reg;
    logic [CNT_W-1:0]      npairs_reg;
    logic [CNT_W-1:0]      lastok_reg;
    logic                  any_ok_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [BLF_W-1:0]      blf_reg;
    logic [FREQ_W-1:0]     o_reg;
    logic [FREQ_W-1:0]     f_reg;
    logic [TGT_W-1:0]      tgt_reg;
    logic [TGT_W-1:0]      a_reg;
    logic [TGT_W-1:0]      d_reg;
    logic [TGT_W-1:0]      bestd_reg;
    logic [FREQ_W-1:0]     best_reg;
    logic                  have_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      t1_reg;
    logic [FREQ_W-1:0]     self_reg;
    logic [ARITH_W-1:0]    num_reg;
    logic [LAT_W-1:0]      lat_reg;
    logic [STATUS_W-1:0]   st_reg;
    arith_req_t            req_reg;
    arith_rsp_t            rsp;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [FREQ_W-1:0]     out_cf_reg;
    logic [FREQ_W-1:0]     out_mf_reg;
    logic [LAT_W-1:0]      out_lat_reg;
    logic                  out_last_reg;

    // Memories
    logic [FREQ_W-1:0]     cpu_mem [LIST_DEPTH];
    logic [FREQ_W-1:0]     mem_mem [LIST_DEPTH];
    logic [KEY_W-1:0]      key_mem [LIST_DEPTH];
    logic [FREQ_W-1:0]     cpu_rd_reg;
    logic [FREQ_W-1:0]     mem_rd_reg;
    logic [KEY_W-1:0]      key_rd_reg;

    logic                  cpu_we;
    logic                  mem_we;
    logic                  key_we;
    logic [IDX_W-1:0]      cpu_wa;
    logic [IDX_W-1:0]      mem_wa;
    logic [IDX_W-1:0]      key_wa;
    logic [IDX_W-1:0]      cpu_ra;
    logic [IDX_W-1:0]      mem_ra;
    logic [IDX_W-1:0]      key_ra;
    logic [FREQ_W-1:0]     list_wd;
    logic [KEY_W-1:0]      key_wd;

    // Derived values
    logic [CNT_W-1:0]      idx_dec;
    logic [CNT_W-1:0]      jdx_dec;
    logic [FREQ_W-1:0]     add_rd;
    logic [FREQ_W-1:0]     outer_rd;
    logic [FREQ_W-1:0]     inner_rd;
    logic [CNT_W-1:0]      outer_n;
    logic [CNT_W-1:0]      inner_n;
    logic [TGT_W-1:0]      abs_diff;
    logic [MAXP_W-1:0]     limit;
    logic [FREQ_W-1:0]     key_cf;
    logic [FREQ_W-1:0]     key_mf;
    logic                  cpu_le;
    logic                  out_free;
    logic                  in_fire;

    rfpb_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // Shared derived values
    always_comb
    begin
        idx_dec  = idx_reg - CNT_W'(1);
        jdx_dec  = jdx_reg - CNT_W'(1);
        add_rd   = add_cpu_reg ? cpu_rd_reg : mem_rd_reg;
        outer_rd = cpu_sweep_reg ? cpu_rd_reg : mem_rd_reg;
        inner_rd = cpu_sweep_reg ? mem_rd_reg : cpu_rd_reg;
        outer_n  = cpu_sweep_reg ? cpu_cnt_reg : mem_cnt_reg;
        inner_n  = cpu_sweep_reg ? mem_cnt_reg : cpu_cnt_reg;
        abs_diff = (a_reg >= tgt_reg) ? (a_reg - tgt_reg) : (tgt_reg - a_reg);
        limit    = (max_pairs_reg == '0 || max_pairs_reg > MAXP_W'(PAIR_LIMIT)) ?
                   MAXP_W'(PAIR_LIMIT) : max_pairs_reg;
        key_cf   = key_reg[KEY_W-1:FREQ_W];
        key_mf   = key_reg[FREQ_W-1:0];
        cpu_le   = (t1_reg <= rsp.result[KEY_W-1:0]);
        out_free = !out_valid_reg || results.ready;
        in_fire  = items.valid && items.ready;
    end

    // Memory port control
    always_comb
    begin
        cpu_we  = 1'b0;
        mem_we  = 1'b0;
        key_we  = 1'b0;
        cpu_wa  = idx_reg[IDX_W-1:0];
        mem_wa  = idx_reg[IDX_W-1:0];
        key_wa  = jdx_reg[IDX_W-1:0];
        cpu_ra  = idx_dec[IDX_W-1:0];
        mem_ra  = idx_dec[IDX_W-1:0];
        key_ra  = idx_reg[IDX_W-1:0];
        list_wd = freq_reg;
        key_wd  = key_reg;
        unique case (state_reg)
            S_ADD_RD:
            begin
                if (idx_reg == '0)
                begin
                    cpu_we = add_cpu_reg;
                    mem_we = !add_cpu_reg;
                end
            end
            S_ADD_CMP:
            begin
                cpu_we  = add_cpu_reg;
                mem_we  = !add_cpu_reg;
                list_wd = (add_rd > freq_reg) ? add_rd : freq_reg;
            end
            S_OUT_RD:
            begin
                cpu_ra = idx_reg[IDX_W-1:0];
                mem_ra = idx_reg[IDX_W-1:0];
            end
            S_IN_RD:
            begin
                cpu_ra = jdx_reg[IDX_W-1:0];
                mem_ra = jdx_reg[IDX_W-1:0];
            end
            S_DUP_RD:
            begin
                key_ra = jdx_reg[IDX_W-1:0];
            end
            S_INS_RD:
            begin
                key_ra = jdx_dec[IDX_W-1:0];
                key_we = (jdx_reg == '0);
            end
            S_INS_CMP:
            begin
                key_we = 1'b1;
                key_wd = (key_rd_reg > key_reg) ? key_rd_reg : key_reg;
            end
            default:
            begin
            end
        endcase
    end

    // List and pair memories with registered read data
    always_ff @(posedge clk)
    begin
        if (cpu_we)
        begin
            cpu_mem[cpu_wa] <= list_wd;
        end
        if (mem_we)
        begin
            mem_mem[mem_wa] <= list_wd;
        end
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        cpu_rd_reg <= cpu_mem[cpu_ra];
        mem_rd_reg <= mem_mem[mem_ra];
        key_rd_reg <= key_mem[key_ra];
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_ratio_reg      <= Q_W'(65536);
            sweep_axis_reg   <= '0;
            max_pairs_reg    <= MAXP_W'(64);
            base_latency_reg <= '0;
            base_flops_reg   <= '0;
            base_cpu_reg     <= '0;
            base_mem_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_K_RATIO:    k_ratio_reg      <= cfg_data[Q_W-1:0];
                REG_SWEEP_AXIS: sweep_axis_reg   <= cfg_data[AXIS_W-1:0];
                REG_MAX_PAIRS:  max_pairs_reg    <= cfg_data[MAXP_W-1:0];
                REG_BASE_LAT:   base_latency_reg <= cfg_data[Q_W-1:0];
                REG_BASE_FLOPS: base_flops_reg   <= cfg_data[FLOPS_W-1:0];
                REG_BASE_CPU:   base_cpu_reg     <= cfg_data[FREQ_W-1:0];
                REG_BASE_MEM:   base_mem_reg     <= cfg_data[FREQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cpu_cnt_reg    <= '0;
            mem_cnt_reg    <= '0;
            add_cpu_reg    <= 1'b0;
            freq_reg       <= '0;
            flops_reg      <= '0;
            ai_reg         <= '0;
            cpu_sweep_reg  <= 1'b0;
            idx_reg        <= '0;
            jdx_reg        <= '0;
            npairs_reg     <= '0;
            lastok_reg     <= '0;
            any_ok_reg     <= 1'b0;
            prod_reg       <= '0;
            blf_reg        <= '0;
            o_reg          <= '0;
            f_reg          <= '0;
            tgt_reg        <= '0;
            a_reg          <= '0;
            d_reg          <= '0;
            bestd_reg      <= '0;
            best_reg       <= '0;
            have_reg       <= 1'b0;
            key_reg        <= '0;
            t1_reg         <= '0;
            self_reg       <= '0;
            num_reg        <= '0;
            lat_reg        <= '0;
            st_reg         <= ST_PAIR;
            req_reg        <= ARITH_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_PAIR;
            out_cf_reg     <= '0;
            out_mf_reg     <= '0;
            out_lat_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                // Take a command
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        freq_reg  <= items.freq;
                        flops_reg <= items.work_flops;
                        ai_reg    <= items.intensity;
                        unique case (items.cmd)
                            CMD_CLEAR:
                            begin
                                cpu_cnt_reg <= '0;
                                mem_cnt_reg <= '0;
                            end
                            CMD_ADD_CPU:
                            begin
                                add_cpu_reg <= 1'b1;
                                idx_reg     <= cpu_cnt_reg;
                                if (cpu_cnt_reg < CNT_W'(LIST_DEPTH))
                                begin
                                    state_reg <= S_ADD_RD;
                                end
                            end
                            CMD_ADD_MEM:
                            begin
                                add_cpu_reg <= 1'b0;
                                idx_reg     <= mem_cnt_reg;
                                if (mem_cnt_reg < CNT_W'(LIST_DEPTH))
                                begin
                                    state_reg <= S_ADD_RD;
                                end
                            end
                            CMD_BUILD:
                            begin
                                state_reg <= S_CHECK;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // Insertion sort into a list, shifting one entry per S_ADD_RD/S_ADD_CMP pass
                S_ADD_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        if (add_cpu_reg)
                        begin
                            cpu_cnt_reg <= cpu_cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            mem_cnt_reg <= mem_cnt_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_ADD_CMP;
                    end
                end
                S_ADD_CMP:
                begin
                    if (add_rd > freq_reg)
                    begin
                        idx_reg   <= idx_dec;
                        state_reg <= S_ADD_RD;
                    end
                    else
                    begin
                        if (add_cpu_reg)
                        begin
                            cpu_cnt_reg <= cpu_cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            mem_cnt_reg <= mem_cnt_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                // Sanity checks in priority order
                S_CHECK:
                begin
                    if (flops_reg == '0 || ai_reg == '0)
                    begin
                        st_reg    <= ST_BAD_FRAME;
                        state_reg <= S_STATUS;
                    end
                    else if (cpu_cnt_reg == '0 || mem_cnt_reg == '0)
                    begin
                        st_reg    <= ST_NO_PAIRS;
                        state_reg <= S_STATUS;
                    end
                    else if (k_ratio_reg == '0)
                    begin
                        st_reg    <= ST_BAD_K;
                        state_reg <= S_STATUS;
                    end
                    else if (base_latency_reg == '0 || base_flops_reg == '0 ||
                             base_cpu_reg == '0 || base_mem_reg == '0)
                    begin
                        st_reg    <= ST_BASE_MISSING;
                        state_reg <= S_STATUS;
                    end
                    else
                    begin
                        cpu_sweep_reg <= (sweep_axis_reg == AXIS_CPU);
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(k_ratio_reg),
                                                 ARITH_W'(ai_reg));
                        state_reg <= S_PROD_WT;
                    end
                end

                // Emit a single status result
                S_STATUS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= st_reg;
                        out_cf_reg     <= '0;
                        out_mf_reg     <= '0;
                        out_lat_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                // k*ai, then base latency times frame flops
                S_PROD_WT:
                begin
                    if (rsp.done)
                    begin
                        prod_reg  <= rsp.result[PROD_W-1:0];
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(base_latency_reg),
                                                 ARITH_W'(flops_reg));
                        state_reg <= S_BLF_WT;
                    end
                end
                S_BLF_WT:
                begin
                    if (rsp.done)
                    begin
                        blf_reg    <= rsp.result[BLF_W-1:0];
                        idx_reg    <= '0;
                        npairs_reg <= '0;
                        state_reg  <= S_OUT_RD;
                    end
                end

                // Outer loop: fetch the sweep entry and its target
                S_OUT_RD:
                begin
                    state_reg <= (idx_reg == outer_n) ? S_LIMIT : S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    o_reg    <= outer_rd;
                    have_reg <= 1'b0;
                    jdx_reg  <= '0;
                    if (cpu_sweep_reg)
                    begin
                        tgt_reg   <= {outer_rd, 32'b0} & TGT_W'({(FREQ_W + 32){1'b1}});
                        state_reg <= S_IN_RD;
                    end
                    else
                    begin
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(prod_reg),
                                                 ARITH_W'(outer_rd));
                        state_reg <= S_TGT_WT;
                    end
                end
                S_TGT_WT:
                begin
                    if (rsp.done)
                    begin
                        tgt_reg   <= rsp.result[TGT_W-1:0];
                        state_reg <= S_IN_RD;
                    end
                end

                // Inner loop: nearest entry, ties keep the lower one
                S_IN_RD:
                begin
                    state_reg <= (jdx_reg == inner_n) ? S_FIN : S_IN_LD;
                end
                S_IN_LD:
                begin
                    f_reg <= inner_rd;
                    if (cpu_sweep_reg)
                    begin
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(prod_reg),
                                                 ARITH_W'(inner_rd));
                        state_reg <= S_A_WT;
                    end
                    else
                    begin
                        a_reg     <= TGT_W'({inner_rd, 32'b0});
                        state_reg <= S_DIFF;
                    end
                end
                S_A_WT:
                begin
                    if (rsp.done)
                    begin
                        a_reg     <= rsp.result[TGT_W-1:0];
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    d_reg     <= abs_diff;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!have_reg || d_reg < bestd_reg)
                    begin
                        have_reg  <= 1'b1;
                        bestd_reg <= d_reg;
                        best_reg  <= f_reg;
                    end
                    jdx_reg   <= jdx_reg + CNT_W'(1);
                    state_reg <= S_IN_RD;
                end

                // Form the pair key, drop zero matches
                S_FIN:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (!have_reg || best_reg == '0)
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        key_reg   <= cpu_sweep_reg ? {o_reg, best_reg} : {best_reg, o_reg};
                        jdx_reg   <= '0;
                        state_reg <= S_DUP_RD;
                    end
                end

                // Drop the key if already listed
                S_DUP_RD:
                begin
                    state_reg <= (jdx_reg == npairs_reg) ? S_INS_RD : S_DUP_CMP;
                end
                S_DUP_CMP:
                begin
                    if (key_rd_reg == key_reg)
                    begin
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        jdx_reg   <= jdx_reg + CNT_W'(1);
                        state_reg <= S_DUP_RD;
                    end
                end

                // Sorted insert of the key
                S_INS_RD:
                begin
                    if (jdx_reg == '0)
                    begin
                        npairs_reg <= npairs_reg + CNT_W'(1);
                        state_reg  <= S_OUT_RD;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (key_rd_reg > key_reg)
                    begin
                        jdx_reg   <= jdx_dec;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        npairs_reg <= npairs_reg + CNT_W'(1);
                        state_reg  <= S_OUT_RD;
                    end
                end

                // Truncate to the pair limit
                S_LIMIT:
                begin
                    if (LIM_W'(npairs_reg) > LIM_W'(limit))
                    begin
                        npairs_reg <= CNT_W'(limit);
                    end
                    idx_reg    <= '0;
                    any_ok_reg <= 1'b0;
                    state_reg  <= S_SCAN_RD;
                end

                // Find the last pair with nonzero scale
                S_SCAN_RD:
                begin
                    if (idx_reg == npairs_reg)
                    begin
                        idx_reg <= '0;
                        if (any_ok_reg)
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            st_reg    <= ST_NO_PAIRS;
                            state_reg <= S_STATUS;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CMP;
                    end
                end
                S_SCAN_CMP:
                begin
                    if (key_rd_reg[KEY_W-1:FREQ_W] != '0 && key_rd_reg[FREQ_W-1:0] != '0)
                    begin
                        lastok_reg <= idx_reg;
                        any_ok_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= S_SCAN_RD;
                end

                // Per pair: pick the limiting ratio, then the latency division
                S_EMIT_RD:
                begin
                    state_reg <= (idx_reg == npairs_reg) ? S_IDLE : S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    key_reg <= key_rd_reg;
                    if (key_rd_reg[KEY_W-1:FREQ_W] == '0 || key_rd_reg[FREQ_W-1:0] == '0)
                    begin
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(base_mem_reg),
                                                 ARITH_W'(key_rd_reg[KEY_W-1:FREQ_W]));
                        state_reg <= S_R1_WT;
                    end
                end
                S_R1_WT:
                begin
                    if (rsp.done)
                    begin
                        t1_reg    <= rsp.result[KEY_W-1:0];
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(base_cpu_reg),
                                                 ARITH_W'(key_mf));
                        state_reg <= S_R2_WT;
                    end
                end
                S_R2_WT:
                begin
                    if (rsp.done)
                    begin
                        self_reg  <= cpu_le ? key_cf : key_mf;
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(blf_reg),
                                         ARITH_W'(cpu_le ? base_cpu_reg : base_mem_reg));
                        state_reg <= S_N_WT;
                    end
                end
                S_N_WT:
                begin
                    if (rsp.done)
                    begin
                        num_reg   <= {rsp.result[ARITH_W-9:0], 8'b0};
                        req_reg   <= arith_issue(ARITH_MUL, ARITH_W'(base_flops_reg),
                                                 ARITH_W'(self_reg));
                        state_reg <= S_D1_WT;
                    end
                end
                S_D1_WT:
                begin
                    if (rsp.done)
                    begin
                        req_reg   <= arith_issue(ARITH_MUL, rsp.result, ARITH_W'(MsPerUs));
                        state_reg <= S_D2_WT;
                    end
                end
                S_D2_WT:
                begin
                    if (rsp.done)
                    begin
                        req_reg   <= arith_issue(ARITH_DIV, num_reg, rsp.result);
                        state_reg <= S_DIV_WT;
                    end
                end
                S_DIV_WT:
                begin
                    if (rsp.done)
                    begin
                        // Saturate the quotient to the output width
                        lat_reg   <= (rsp.result[ARITH_W-1:LAT_W] != '0) ?
                                     {LAT_W{1'b1}} : rsp.result[LAT_W-1:0];
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_PAIR;
                        out_cf_reg     <= key_cf;
                        out_mf_reg     <= key_mf;
                        out_lat_reg    <= lat_reg;
                        out_last_reg   <= (idx_reg == lastok_reg);
                        idx_reg        <= idx_reg + CNT_W'(1);
                        state_reg      <= S_EMIT_RD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs
    assign items.ready        = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.status     = out_status_reg;
    assign results.cpu_freq   = out_cf_reg;
    assign results.mem_freq   = out_mf_reg;
    assign results.latency_ms = out_lat_reg;
    assign results.last       = out_last_reg;

    // Arithmetic completions only arrive while the sequencer waits on them
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_PROD_WT || state_reg == S_BLF_WT ||
                      state_reg == S_TGT_WT || state_reg == S_A_WT ||
                      state_reg == S_R1_WT || state_reg == S_R2_WT ||
                      state_reg == S_N_WT || state_reg == S_D1_WT ||
                      state_reg == S_D2_WT || state_reg == S_DIV_WT))
        else $error("arithmetic result arrived outside a wait state");

    // A non-final item handed off means the build is still running
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && !results.last) |=> (state_reg != S_IDLE))
        else $error("build ended without a final item");

    // Counts never pass the storage depth
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cpu_cnt_reg <= CNT_W'(LIST_DEPTH)) && (mem_cnt_reg <= CNT_W'(LIST_DEPTH)) &&
        (npairs_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list or pair count beyond depth");

endmodule

FILE: rtl/core/rfpb_arith.sv
// Shared arithmetic unit: shift-add multiplier and restoring divider.
// One bit of work per cycle; depends on rfpb_pkg.
module rfpb_arith (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rfpb_pkg::arith_req_t req,
    output rfpb_pkg::arith_rsp_t rsp
);
    import rfpb_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    logic               busy_reg;
    logic               done_reg;
    arith_op_t          op_reg;
    logic [ARITH_W-1:0] acc_reg;
    logic [ARITH_W-1:0] x_reg;
    logic [ARITH_W-1:0] y_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [ARITH_W-1:0] shifted;
    logic               fits;

    // Partial remainder with the next dividend bit
    always_comb
    begin
        shifted = {acc_reg[ARITH_W-2:0], x_reg[ARITH_W-1]};
        fits    = (shifted >= y_reg);
    end

    // Run one step per cycle until the multiplier empties or all quotient bits are out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ARITH_MUL;
            acc_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                acc_reg  <= '0;
                x_reg    <= req.a;
                y_reg    <= req.b;
                step_reg <= STEP_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                unique case (op_reg)
                    ARITH_MUL:
                    begin
                        if (y_reg == '0)
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            if (y_reg[0])
                            begin
                                acc_reg <= acc_reg + x_reg;
                            end
                            x_reg <= {x_reg[ARITH_W-2:0], 1'b0};
                            y_reg <= {1'b0, y_reg[ARITH_W-1:1]};
                        end
                    end
                    ARITH_DIV:
                    begin
                        acc_reg  <= fits ? (shifted - y_reg) : shifted;
                        x_reg    <= {x_reg[ARITH_W-2:0], fits};
                        step_reg <= step_reg - STEP_W'(1);
                        if (step_reg == STEP_W'(1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == ARITH_MUL) ? acc_reg : x_reg;

endmodule

FILE: sim/tb_top.sv
// Testbench for ridge_frequency_pair_builder_core: directed table, then random phases.
// Depends on rfpb_pkg, rfpb_item_if, rfpb_result_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import rfpb_pkg::*;

    localparam int DEPTH      = 16;
    localparam int MAX_KEPT   = 64;
    localparam int DRAIN_WAIT = 300;
    localparam int DOG_LIMIT  = 200000;
    localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FREQ_W-1:0]   cpu_freq;
        logic [FREQ_W-1:0]   mem_freq;
        logic [LAT_W-1:0]    latency_ms;
        logic                last;
    } pair_res_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic [CMD_W-1:0]      cmd;
        logic [FREQ_W-1:0]     freq;
        logic [FLOPS_W-1:0]    flops;
        logic [Q_W-1:0]        ai;
        bit                    typed;
        logic [STATUS_W-1:0]   typed_status;
    } step_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rfpb_item_if   item_ch ();
    rfpb_result_if res_ch ();

    ridge_frequency_pair_builder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of registers and lists
    logic [31:0] k_ratio_q;
    logic [1:0]  axis_q;
    logic [6:0]  max_pairs_q;
    logic [31:0] base_lat_q;
    logic [47:0] base_flops_q;
    logic [23:0] base_cpu_q;
    logic [23:0] base_mem_q;
    logic [23:0] cpu_tab [DEPTH];
    logic [23:0] mem_tab [DEPTH];
    int          cpu_cnt;
    int          mem_cnt;

    pair_res_t expected_pairs [$];
    int        errors;
    int        src_idle_pct;
    int        sink_stall_pct;
    int        dog_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pair_res_t status_res(input logic [STATUS_W-1:0] st);
        pair_res_t r;
        r = '0;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // Insert into an ascending list, drop when full
    task automatic list_insert(input bit to_cpu, input logic [23:0] f);
        int i;
        if (to_cpu)
        begin
            if (cpu_cnt >= DEPTH)
                return;
            i = cpu_cnt;
            while (i > 0 && cpu_tab[i-1] > f)
            begin
                cpu_tab[i] = cpu_tab[i-1];
                i--;
            end
            cpu_tab[i] = f;
            cpu_cnt++;
        end
        else
        begin
            if (mem_cnt >= DEPTH)
                return;
            i = mem_cnt;
            while (i > 0 && mem_tab[i-1] > f)
            begin
                mem_tab[i] = mem_tab[i-1];
                i--;
            end
            mem_tab[i] = f;
            mem_cnt++;
        end
    endtask

    // Compute the results that one accepted item causes
    task automatic predict_pairs(input logic [CMD_W-1:0] cmd, input logic [23:0] freq,
                                 input logic [47:0] flops, input logic [31:0] ai,
                                 output pair_res_t outq [$]);
        logic [63:0]  prod;
        logic [127:0] tgt, a, d, bestd, num, den, q, sel_b, sel_f;
        logic [23:0]  o, f, best, cf, mf;
        logic [47:0]  key, lhs, rhs;
        logic [47:0]  keys [$];
        bit           cpu_sweep, have, dup;
        int           outer_n, inner_n, limit, p;
        pair_res_t    r;
        outq = {};
        case (cmd)
            CMD_CLEAR:
            begin
                cpu_cnt = 0;
                mem_cnt = 0;
                return;
            end
            CMD_ADD_CPU:
            begin
                list_insert(1'b1, freq);
                return;
            end
            CMD_ADD_MEM:
            begin
                list_insert(1'b0, freq);
                return;
            end
            default: ;
        endcase
        if (flops == 0 || ai == 0)
        begin
            outq.push_back(status_res(ST_BAD_FRAME));
            return;
        end
        if (cpu_cnt == 0 || mem_cnt == 0)
        begin
            outq.push_back(status_res(ST_NO_PAIRS));
            return;
        end
        if (k_ratio_q == 0)
        begin
            outq.push_back(status_res(ST_BAD_K));
            return;
        end
        if (base_lat_q == 0 || base_flops_q == 0 || base_cpu_q == 0 || base_mem_q == 0)
        begin
            outq.push_back(status_res(ST_BASE_MISSING));
            return;
        end
        prod = 64'(k_ratio_q) * 64'(ai);
        cpu_sweep = (axis_q == AXIS_CPU);
        outer_n = cpu_sweep ? cpu_cnt : mem_cnt;
        inner_n = cpu_sweep ? mem_cnt : cpu_cnt;
        // Nearest match per outer entry, lower frequency wins a tie
        for (int i = 0; i < outer_n; i++)
        begin
            o = cpu_sweep ? cpu_tab[i] : mem_tab[i];
            tgt = cpu_sweep ? (128'(o) << 32) : 128'(o) * 128'(prod);
            have = 1'b0;
            best = '0;
            bestd = '0;
            for (int j = 0; j < inner_n; j++)
            begin
                f = cpu_sweep ? mem_tab[j] : cpu_tab[j];
                a = cpu_sweep ? 128'(f) * 128'(prod) : (128'(f) << 32);
                d = (a >= tgt) ? a - tgt : tgt - a;
                if (!have || d < bestd)
                begin
                    have = 1'b1;
                    bestd = d;
                    best = f;
                end
            end
            if (!have || best == 0)
                continue;
            key = cpu_sweep ? {o, best} : {best, o};
            dup = 1'b0;
            foreach (keys[m])
                if (keys[m] == key)
                    dup = 1'b1;
            if (dup)
                continue;
            p = keys.size();
            while (p > 0 && keys[p-1] > key)
                p--;
            keys.insert(p, key);
        end
        limit = (max_pairs_q == 0 || max_pairs_q > MAX_KEPT) ? MAX_KEPT : int'(max_pairs_q);
        while (keys.size() > limit)
            void'(keys.pop_back());
        // Latency per kept pair, scaled by the slower side
        foreach (keys[i])
        begin
            cf = keys[i][47:24];
            mf = keys[i][23:0];
            if (cf == 0 || mf == 0)
                continue;
            lhs = 48'(cf) * 48'(base_mem_q);
            rhs = 48'(mf) * 48'(base_cpu_q);
            if (lhs <= rhs)
            begin
                sel_f = 128'(cf);
                sel_b = 128'(base_cpu_q);
            end
            else
            begin
                sel_f = 128'(mf);
                sel_b = 128'(base_mem_q);
            end
            num = 128'(base_lat_q) * 128'(flops);
            num = num * (sel_b << 8);
            den = 128'(base_flops_q) * sel_f;
            den = den * 128'(MsPerUs);
            q = num / den;
            r.status = ST_PAIR;
            r.cpu_freq = cf;
            r.mem_freq = mf;
            r.latency_ms = (q > 128'(M48)) ? M48 : q[47:0];
            r.last = 1'b0;
            outq.push_back(r);
        end
        if (outq.size() == 0)
            outq.push_back(status_res(ST_NO_PAIRS));
        else
            outq[outq.size()-1].last = 1'b1;
    endtask

    // Write one register; caller lowers cfg_we after the batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            REG_K_RATIO:    k_ratio_q    = v[31:0];
            REG_SWEEP_AXIS: axis_q       = v[1:0];
            REG_MAX_PAIRS:  max_pairs_q  = v[6:0];
            REG_BASE_LAT:   base_lat_q   = v[31:0];
            REG_BASE_FLOPS: base_flops_q = v[47:0];
            REG_BASE_CPU:   base_cpu_q   = v[23:0];
            REG_BASE_MEM:   base_mem_q   = v[23:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Hold until all results are back and the sequencer has settled
    task automatic wait_idle();
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Drive one item, with random gaps; valid stays high between back-to-back items
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [23:0] freq,
                             input logic [47:0] flops, input logic [31:0] ai,
                             input bit typed, input logic [STATUS_W-1:0] typed_status);
        pair_res_t outq [$];
        if ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= cmd;
        item_ch.freq       <= freq;
        item_ch.work_flops <= flops;
        item_ch.intensity  <= ai;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predict_pairs(cmd, freq, flops, ai, outq);
        if (typed)
            expected_pairs.push_back(status_res(typed_status));
        else
            foreach (outq[i])
                expected_pairs.push_back(outq[i]);
    endtask

    function automatic step_t item_row(input logic [CMD_W-1:0] cmd, input logic [23:0] freq,
                                       input logic [47:0] flops, input logic [31:0] ai,
                                       input bit typed = 0,
                                       input logic [STATUS_W-1:0] st = ST_PAIR);
        step_t s;
        s = '{default: '0};
        s.cmd = cmd;
        s.freq = freq;
        s.flops = flops;
        s.ai = ai;
        s.typed = typed;
        s.typed_status = st;
        return s;
    endfunction

    function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] v);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.value = v;
        return s;
    endfunction

    function automatic logic [23:0] pick_freq();
        int c;
        c = $urandom_range(99);
        if (c < 70)
            return 24'($urandom_range(1, 4000) * 100);
        else if (c < 95)
            return 24'($urandom);
        else
            return (c < 97) ? 24'd0 : 24'hFFFFFF;
    endfunction

    function automatic logic [47:0] pick_flops();
        int c;
        c = $urandom_range(99);
        if (c < 60)
            return 48'($urandom_range(1, 1000000));
        else if (c < 95)
            return {$urandom, $urandom};
        else
            return (c < 97) ? 48'd0 : M48;
    endfunction

    function automatic logic [31:0] pick_ai();
        int c;
        c = $urandom_range(99);
        if (c < 60)
            return 32'($urandom_range(32'h4000, 32'h40000));
        else if (c < 95)
            return $urandom;
        else
            return (c < 97) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    // Phase settings: one all-maximum, one all-minimum, the rest random
    task automatic config_phase(input int ph);
        logic [47:0] v [7];
        if (ph == 1)
        begin
            v = '{48'hFFFF_FFFF, 48'd3, 48'd127, 48'hFFFF_FFFF, M48, 48'hFFFFFF, 48'hFFFFFF};
        end
        else if (ph == 5)
        begin
            v = '{48'd1, 48'd0, 48'd0, 48'd1, 48'd1, 48'd1, 48'd1};
        end
        else
        begin
            case ($urandom_range(3))
                0: v[0] = 48'd65536;
                1: v[0] = 48'($urandom_range(32'h8000, 32'h20000));
                2: v[0] = 48'($urandom);
                default: v[0] = ($urandom_range(1) != 0) ? 48'd0 : 48'hFFFF_FFFF;
            endcase
            v[1] = 48'($urandom_range(3));
            v[2] = 48'($urandom_range(127));
            v[3] = ($urandom_range(9) == 0) ? 48'd0 : 48'($urandom);
            v[4] = ($urandom_range(1) != 0) ? 48'($urandom_range(1, 1000000))
                                            : {$urandom, $urandom};
            v[5] = 48'($urandom_range(1) != 0 ? $urandom_range(100, 400000) : $urandom);
            v[6] = 48'($urandom_range(1) != 0 ? $urandom_range(100, 400000) : $urandom);
            v[4] = v[4] & M48;
            v[5] = v[5] & 48'hFFFFFF;
            v[6] = v[6] & 48'hFFFFFF;
        end
        for (int i = 0; i < 7; i++)
            write_reg(CFG_IDX_W'(i), v[i]);
        cfg_we <= 1'b0;
    endtask

    // Result checker and sink stalls
    always @(posedge clk)
    begin
        pair_res_t got;
        pair_res_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            got.status     = res_ch.status;
            got.cpu_freq   = res_ch.cpu_freq;
            got.mem_freq   = res_ch.mem_freq;
            got.latency_ms = res_ch.latency_ms;
            got.last       = res_ch.last;
            if (expected_pairs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status=%0d cpu=%0d mem=%0d lat=%0h last=%0b",
                         $time, got.status, got.cpu_freq, got.mem_freq, got.latency_ms,
                         got.last);
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (got.status != want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.cpu_freq != want.cpu_freq)
                    $display("%0t: cpu_freq expected %0d actual %0d", $time,
                             want.cpu_freq, got.cpu_freq);
                if (got.mem_freq != want.mem_freq)
                    $display("%0t: mem_freq expected %0d actual %0d", $time,
                             want.mem_freq, got.mem_freq);
                if (got.latency_ms != want.latency_ms)
                    $display("%0t: latency_ms expected %0h actual %0h", $time,
                             want.latency_ms, got.latency_ms);
                if (got.last != want.last)
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                if (got != want)
                    errors++;
            end
        end
        res_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            dog_count <= 0;
        else
            dog_count <= dog_count + 1;
        if (dog_count >= DOG_LIMIT)
        begin
            $display("ridge_frequency_pair_builder_core test failed");
            $finish;
        end
    end

    initial
    begin
        step_t steps [$];
        int    n_items;
        int    n_adds;
        int    c;
        errors = 0;
        dog_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = CMD_CLEAR;
        item_ch.freq = '0;
        item_ch.work_flops = '0;
        item_ch.intensity = '0;
        res_ch.ready = 1'b0;
        k_ratio_q = 32'd65536;
        axis_q = '0;
        max_pairs_q = 7'd64;
        base_lat_q = '0;
        base_flops_q = '0;
        base_cpu_q = '0;
        base_mem_q = '0;
        cpu_cnt = 0;
        mem_cnt = 0;
        foreach (cpu_tab[i])
        begin
            cpu_tab[i] = '0;
            mem_tab[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: status codes, every command, axis codes, limits, saturation
        steps.push_back(item_row(CMD_BUILD, 0, 48'd0, 32'd1, 1, ST_BAD_FRAME));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1, 32'd0, 1, ST_BAD_FRAME));
        steps.push_back(item_row(CMD_BUILD, 24'hFFFFFF, M48, 32'hFFFF_FFFF, 1, ST_NO_PAIRS));
        steps.push_back(item_row(CMD_ADD_CPU, 24'd2000, 0, 0));
        steps.push_back(item_row(CMD_ADD_CPU, 24'd1000, 0, 0));
        steps.push_back(item_row(CMD_ADD_MEM, 24'd500, 0, 0));
        steps.push_back(item_row(CMD_ADD_MEM, 24'd1500, 0, 0));
        steps.push_back(cfg_row(REG_K_RATIO, 48'd0));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000, 32'h10000, 1, ST_BAD_K));
        steps.push_back(cfg_row(REG_K_RATIO, 48'd65536));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000, 32'h10000, 1, ST_BASE_MISSING));
        steps.push_back(cfg_row(REG_BASE_LAT, 48'd25600));
        steps.push_back(cfg_row(REG_BASE_FLOPS, 48'd1000000));
        steps.push_back(cfg_row(REG_BASE_CPU, 48'd1000));
        steps.push_back(cfg_row(REG_BASE_MEM, 48'd500));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000000, 32'h10000));
        steps.push_back(cfg_row(REG_SWEEP_AXIS, 48'd1));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000000, 32'h18000));
        steps.push_back(cfg_row(REG_SWEEP_AXIS, 48'd3));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000000, 32'h8000));
        steps.push_back(cfg_row(REG_SWEEP_AXIS, 48'd2));
        steps.push_back(cfg_row(REG_MAX_PAIRS, 48'd1));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd1000000, 32'h20000));
        steps.push_back(cfg_row(REG_MAX_PAIRS, 48'd127));
        steps.push_back(item_row(CMD_ADD_CPU, 24'd0, 0, 0));
        steps.push_back(item_row(CMD_ADD_MEM, 24'd0, 0, 0));
        steps.push_back(item_row(CMD_ADD_CPU, 24'hFFFFFF, 0, 0));
        steps.push_back(item_row(CMD_ADD_MEM, 24'hFFFFFF, 0, 0));
        steps.push_back(item_row(CMD_BUILD, 0, M48, 32'hFFFF_FFFF));
        steps.push_back(item_row(CMD_BUILD, 0, M48, 32'h1));
        steps.push_back(item_row(CMD_CLEAR, 0, 0, 0));
        steps.push_back(item_row(CMD_BUILD, 0, 48'd5, 32'd5, 1, ST_NO_PAIRS));

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
            begin
                item_ch.valid <= 1'b0;
                wait_idle();
                write_reg(steps[i].reg_idx, steps[i].value);
                cfg_we <= 1'b0;
            end
            else
                send_item(steps[i].cmd, steps[i].freq, steps[i].flops, steps[i].ai,
                          steps[i].typed, steps[i].typed_status);
        end

        // Random phases: two per idling mode
        for (int ph = 0; ph < 8; ph++)
        begin
            item_ch.valid <= 1'b0;
            wait_idle();
            config_phase(ph);
            case (ph / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            n_items = 0;
            while (n_items < 14)
            begin
                c = $urandom_range(99);
                if (c < 10)
                begin
                    // noise item with random fields
                    send_item(CMD_W'($urandom), 24'($urandom), {$urandom, $urandom},
                              $urandom, 0, ST_PAIR);
                    n_items++;
                    continue;
                end
                if (c < 40)
                begin
                    send_item(CMD_CLEAR, 24'($urandom), {$urandom, $urandom}, $urandom,
                              0, ST_PAIR);
                    n_items++;
                end
                // a list load followed by builds
                n_adds = $urandom_range(1, 18);
                for (int a = 0; a < n_adds; a++)
                    send_item(($urandom_range(1) != 0) ? CMD_ADD_CPU : CMD_ADD_MEM,
                              pick_freq(), {$urandom, $urandom}, $urandom, 0, ST_PAIR);
                n_items += n_adds;
                for (int b = $urandom_range(1, 2); b > 0; b--)
                begin
                    send_item(CMD_BUILD, 24'($urandom), pick_flops(), pick_ai(), 0, ST_PAIR);
                    n_items++;
                end
            end
        end
        item_ch.valid <= 1'b0;
        sink_stall_pct = 0;
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("ridge_frequency_pair_builder_core test passed");
        else
            $display("ridge_frequency_pair_builder_core test failed");
        $finish;
    end
endmodule

FILE: ridge_frequency_pair_builder_core.f
rtl/core/rfpb_pkg.sv
rtl/core/rfpb_item_if.sv
rtl/core/rfpb_result_if.sv
rtl/core/rfpb_arith.sv
rtl/core/ridge_frequency_pair_builder_core.sv
sim/tb_top.sv
